// ===== sv/psab_pkg.sv =====
// Shared types and constants for the priority slot allocator with linear backoff.
// Used by psab_slot and priority_server_allocator_backoff; no dependencies.
`default_nettype none
package psab_pkg;

  localparam int unsigned AgentW   = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned PenaltyW = 24;
  localparam int unsigned StepW    = 8;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [AgentW-1:0] NO_OWNER = '1;

  localparam logic [ModeW-1:0] MODE_ACQUIRE      = 3'd0;
  localparam logic [ModeW-1:0] MODE_RELEASE      = 3'd1;
  localparam logic [ModeW-1:0] MODE_FAIL         = 3'd2;
  localparam logic [ModeW-1:0] MODE_FAIL_ACQUIRE = 3'd3;
  localparam logic [ModeW-1:0] MODE_TICK         = 3'd4;
  localparam logic [ModeW-1:0] MODE_LOOKUP       = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_PRESENT_MASK = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_BACKOFF_STEP = 8'd1;

  localparam logic [StepW-1:0] BACKOFF_RESET = 8'd15;

  typedef struct packed {
    logic do_free;
    logic penalize;
    logic tick;
  } slot_cmd_t;

  typedef struct packed {
    logic owned;
    logic grantable;
    logic avail;
  } slot_stat_t;

endpackage
`default_nettype wire

// ===== sv/psab_slot.sv =====
// One allocator slot: owner id, error count and penalty countdown.
// Depends on psab_pkg.
`default_nettype none
module psab_slot
  import psab_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              present_i,
  input  wire logic [AgentW-1:0] agent_i,
  input  wire logic [StepW-1:0]  step_i,
  input  wire slot_cmd_t         cmd_i,
  input  wire logic              grant_i,
  output slot_stat_t             stat_o
);

  logic [AgentW-1:0]   owner_q, owner_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [PenaltyW-1:0] pen_q, pen_d;
  logic [PenaltyW-1:0] prod;
  logic                owned, freed, pen_zero_next;

  assign owned = present_i && (agent_i != NO_OWNER) && (owner_q == agent_i);
  assign freed = cmd_i.do_free && owned;
  assign prod  = {{(PenaltyW-CountW){1'b0}}, cnt_q} * {{(PenaltyW-StepW){1'b0}}, step_i};

  always_comb begin
    if (freed && cmd_i.penalize) begin
      pen_zero_next = (cnt_q == '0) || (step_i == '0);
    end else if (cmd_i.tick) begin
      pen_zero_next = (pen_q <= PenaltyW'(1));
    end else begin
      pen_zero_next = (pen_q == '0);
    end
  end

  assign stat_o.owned     = owned;
  assign stat_o.grantable = present_i && ((owner_q == NO_OWNER) || freed) && pen_zero_next;
  assign stat_o.avail     = present_i && pen_zero_next;

  always_comb begin
    owner_d = owner_q;
    cnt_d   = cnt_q;
    pen_d   = pen_q;
    if (grant_i) begin
      owner_d = agent_i;
    end else if (freed) begin
      owner_d = NO_OWNER;
    end
    if (freed && cmd_i.penalize) begin
      pen_d = prod;
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CountW'(1);
      end
    end else if (cmd_i.tick && (pen_q != '0)) begin
      pen_d = pen_q - PenaltyW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= NO_OWNER;
      cnt_q   <= '0;
      pen_q   <= '0;
    end else begin
      owner_q <= owner_d;
      cnt_q   <= cnt_d;
      pen_q   <= pen_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/priority_server_allocator_backoff.sv =====
// Top level of the priority slot allocator with linear backoff.
// Depends on psab_pkg and psab_slot.
//
// Usage:
//   Command channel: raise start_i with mode_i and agent_id_i; the command is
//   taken at a clock edge where start_i is high and busy_o is low. busy_o is
//   always low, so a command may be issued every cycle.
//   Result channel: done_o pulses for one cycle with granted_o, grant_index_o,
//   released_mask_o, lookup_found_o, lookup_index_o and any_available_o. The
//   receiver must take the result in that cycle; it cannot hold it off.
//   Pipeline: one input register, then one pass through the slot array
//   (owner compare, priority pick, penalty update) into the result register.
//   Throughput is one command per cycle; slot state updates at the same edge
//   as the result register, so back-to-back commands see each other's effect.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 writes present_mask, index 1 writes backoff_step, others drop.
//   cfg_ready_o is always high. Write only while no command is in flight.
//   Reset: all slots unowned with zero error count and penalty, present_mask
//   zero, backoff_step 15, no result pending.
`default_nettype none
module priority_server_allocator_backoff
  import psab_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [ModeW-1:0]   mode_i,
  input  wire logic [AgentW-1:0]  agent_id_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [MaskW-1:0]   cfg_data_i,
  output logic                    done_o,
  output logic                    granted_o,
  output logic [IdxW-1:0]         grant_index_o,
  output logic [MaskW-1:0]        released_mask_o,
  output logic                    lookup_found_o,
  output logic [IdxW-1:0]         lookup_index_o,
  output logic                    any_available_o
);

  logic [MaskW-1:0]  present_q;
  logic [StepW-1:0]  step_q;
  logic              req_valid_q;
  logic [ModeW-1:0]  mode_q;
  logic [AgentW-1:0] agent_q;

  slot_cmd_t            cmd;
  slot_stat_t           stat [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] present, owned, grantable, avail, grant_oh, freed;
  logic                 acq_en, lookup_en;
  logic [IdxW-1:0]      gidx, lidx;
  logic [MaskW-1:0]     released;

  logic             done_q, granted_q, found_q, avail_q;
  logic [IdxW-1:0]  gidx_q, lidx_q;
  logic [MaskW-1:0] released_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      step_q    <= BACKOFF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PRESENT_MASK: present_q <= cfg_data_i;
        REG_BACKOFF_STEP: step_q    <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      mode_q  <= mode_i;
      agent_q <= agent_id_i;
    end
  end

  always_comb begin
    cmd       = '0;
    acq_en    = 1'b0;
    lookup_en = 1'b0;
    if (req_valid_q) begin
      case (mode_q)
        MODE_ACQUIRE: acq_en = (agent_q != NO_OWNER);
        MODE_RELEASE: cmd.do_free = 1'b1;
        MODE_FAIL: begin
          cmd.do_free  = 1'b1;
          cmd.penalize = 1'b1;
        end
        MODE_FAIL_ACQUIRE: begin
          cmd.do_free  = 1'b1;
          cmd.penalize = 1'b1;
          acq_en       = (agent_q != NO_OWNER);
        end
        MODE_TICK:   cmd.tick  = 1'b1;
        MODE_LOOKUP: lookup_en = 1'b1;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    if (i < MaskW) begin : g_pres
      assign present[i] = present_q[i];
    end else begin : g_abs
      assign present[i] = 1'b0;
    end

    psab_slot u_slot (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .present_i (present[i]),
      .agent_i   (agent_q),
      .step_i    (step_q),
      .cmd_i     (cmd),
      .grant_i   (grant_oh[i]),
      .stat_o    (stat[i])
    );

    assign owned[i]     = stat[i].owned;
    assign grantable[i] = stat[i].grantable;
    assign avail[i]     = stat[i].avail;
    assign freed[i]     = cmd.do_free && stat[i].owned;
  end

  assign grant_oh = acq_en ? (grantable & (~grantable + NUM_SLOTS'(1))) : '0;

  for (genvar b = 0; b < MaskW; b++) begin : g_rel
    if (b < NUM_SLOTS) begin : g_on
      assign released[b] = freed[b];
    end else begin : g_off
      assign released[b] = 1'b0;
    end
  end

  always_comb begin
    gidx = '0;
    lidx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (grant_oh[i]) begin
        gidx = IdxW'(i);
      end
      if (owned[i]) begin
        lidx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      granted_q  <= |grant_oh;
      gidx_q     <= gidx;
      released_q <= released;
      found_q    <= lookup_en && (|owned);
      lidx_q     <= lookup_en ? lidx : '0;
      avail_q    <= |avail;
    end
  end

  assign done_o          = done_q;
  assign granted_o       = granted_q;
  assign grant_index_o   = gidx_q;
  assign released_mask_o = released_q;
  assign lookup_found_o  = found_q;
  assign lookup_index_o  = lidx_q;
  assign any_available_o = avail_q;

endmodule
`default_nettype wire

// ===== verif/priority_server_allocator_backoff_tb.sv =====
`timescale 1ns / 1ps
// Testbench for priority_server_allocator_backoff: drives commands and register writes,
// predicts every result with its own slot-table model and checks each done_o transaction.
// Depends on psab_pkg and the priority_server_allocator_backoff RTL.
module priority_server_allocator_backoff_tb;
  import psab_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned Latency  = 2;
  localparam int unsigned PoolSize = 6;

  localparam logic [ModeW-1:0]   MODE_SPARE_LO  = 3'd6;
  localparam logic [ModeW-1:0]   MODE_SPARE_HI  = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LAST_INDEX = 8'hFF;

  typedef struct packed {
    logic            granted;
    logic [IdxW-1:0] grant_index;
    logic [MaskW-1:0] released_mask;
    logic            lookup_found;
    logic [IdxW-1:0] lookup_index;
    logic            any_available;
  } alloc_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [ModeW-1:0]   mode_i;
  logic [AgentW-1:0]  agent_id_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [MaskW-1:0]   cfg_data_i;
  logic               done_o;
  logic               granted_o;
  logic [IdxW-1:0]    grant_index_o;
  logic [MaskW-1:0]   released_mask_o;
  logic               lookup_found_o;
  logic [IdxW-1:0]    lookup_index_o;
  logic               any_available_o;

  logic [AgentW-1:0]   owner_q      [NumSlots];
  logic [CountW-1:0]   fail_count_q [NumSlots];
  logic [PenaltyW-1:0] penalty_q    [NumSlots];
  logic [MaskW-1:0]    present_q;
  logic [StepW-1:0]    step_q;
  logic [AgentW-1:0]   agent_pool   [PoolSize];

  alloc_result_t expected_results[$];
  int unsigned   errors;
  bit            idle_en;

  priority_server_allocator_backoff #(
    .NUM_SLOTS(NumSlots)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .agent_id_i     (agent_id_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .granted_o      (granted_o),
    .grant_index_o  (grant_index_o),
    .released_mask_o(released_mask_o),
    .lookup_found_o (lookup_found_o),
    .lookup_index_o (lookup_index_o),
    .any_available_o(any_available_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [MaskW-1:0] free_owned_slots(input logic [AgentW-1:0] agent,
                                                        input bit penalize);
    logic [MaskW-1:0] freed;
    logic [31:0]      cost;
    freed = '0;
    if (agent == NO_OWNER) return freed;
    for (int i = 0; i < NumSlots; i++) begin
      if (i < MaskW && present_q[i] && owner_q[i] == agent) begin
        owner_q[i] = NO_OWNER;
        if (penalize) begin
          cost = 32'(fail_count_q[i]) * 32'(step_q);
          penalty_q[i] = (cost > 32'h00FF_FFFF) ? '1 : cost[PenaltyW-1:0];
          if (fail_count_q[i] != '1) fail_count_q[i] = fail_count_q[i] + CountW'(1);
        end
        freed[i] = 1'b1;
      end
    end
    return freed;
  endfunction

  function automatic logic grant_lowest_slot(input logic [AgentW-1:0] agent,
                                             output logic [IdxW-1:0] idx);
    idx = '0;
    if (agent == NO_OWNER) return 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      if (i < MaskW && present_q[i] && owner_q[i] == NO_OWNER && penalty_q[i] == '0) begin
        owner_q[i] = agent;
        idx = IdxW'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_result(input logic [ModeW-1:0] mode,
                                                   input logic [AgentW-1:0] agent);
    alloc_result_t   r;
    logic [IdxW-1:0] idx;
    r = '0;
    case (mode)
      MODE_ACQUIRE: begin
        r.granted     = grant_lowest_slot(agent, idx);
        r.grant_index = idx;
      end
      MODE_RELEASE: r.released_mask = free_owned_slots(agent, 1'b0);
      MODE_FAIL:    r.released_mask = free_owned_slots(agent, 1'b1);
      MODE_FAIL_ACQUIRE: begin
        r.released_mask = free_owned_slots(agent, 1'b1);
        r.granted       = grant_lowest_slot(agent, idx);
        r.grant_index   = idx;
      end
      MODE_TICK: begin
        for (int i = 0; i < NumSlots; i++)
          if (penalty_q[i] != '0) penalty_q[i] = penalty_q[i] - PenaltyW'(1);
      end
      MODE_LOOKUP: begin
        if (agent != NO_OWNER) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (i < MaskW && present_q[i] && owner_q[i] == agent) begin
              r.lookup_found = 1'b1;
              r.lookup_index = IdxW'(i);
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NumSlots; i++)
      if (i < MaskW && present_q[i] && penalty_q[i] == '0) r.any_available = 1'b1;
    return r;
  endfunction

  task automatic send_cmd(input logic [ModeW-1:0] mode, input logic [AgentW-1:0] agent);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start_i    = 1'b0;
      mode_i     = ModeW'($urandom);
      agent_id_i = $urandom;
    end
    @(negedge clk_i);
    start_i    = 1'b1;
    mode_i     = mode;
    agent_id_i = agent;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_results = {expected_results, predict_result(mode, agent)};
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MaskW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_PRESENT_MASK: present_q = data;
      REG_BACKOFF_STEP: step_q = data[StepW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgIdxW'($urandom);
    cfg_data_i  = MaskW'($urandom);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none actual granted %0b index %0h",
                 $time, granted_o, grant_index_o);
      end else begin
        want = expected_results.pop_front();
        check_field("granted", 32'(want.granted), 32'(granted_o));
        check_field("grant_index", 32'(want.grant_index), 32'(grant_index_o));
        check_field("released_mask", 32'(want.released_mask), 32'(released_mask_o));
        check_field("lookup_found", 32'(want.lookup_found), 32'(lookup_found_o));
        check_field("lookup_index", 32'(want.lookup_index), 32'(lookup_index_o));
        check_field("any_available", 32'(want.any_available), 32'(any_available_o));
      end
    end
  end

  task automatic test_config_regs();
    send_cmd(MODE_ACQUIRE, agent_pool[0]);
    send_cmd(MODE_TICK, NO_OWNER);
    settle();
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(REG_LAST_INDEX, 16'hFFFF);
    send_cmd(MODE_ACQUIRE, agent_pool[0]);
    settle();
    write_reg(REG_PRESENT_MASK, 16'hFFFF);
    write_reg(REG_BACKOFF_STEP, 16'hFF03);
  endtask

  task automatic test_grant_order();
    send_cmd(MODE_ACQUIRE, 32'h0000_0000);
    send_cmd(MODE_ACQUIRE, 32'hFFFF_FFFE);
    send_cmd(MODE_ACQUIRE, NO_OWNER);
    send_cmd(MODE_LOOKUP, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'hFFFF_FFFE);
    send_cmd(MODE_LOOKUP, NO_OWNER);
    send_cmd(MODE_ACQUIRE, 32'h0000_0000);
    send_cmd(MODE_LOOKUP, 32'h0000_0000);
    send_cmd(MODE_SPARE_LO, 32'h0000_0000);
    send_cmd(MODE_SPARE_HI, 32'hFFFF_FFFE);
    send_cmd(MODE_RELEASE, 32'h0000_0000);
    send_cmd(MODE_RELEASE, NO_OWNER);
    send_cmd(MODE_FAIL, NO_OWNER);
  endtask

  task automatic test_fail_backoff();
    send_cmd(MODE_ACQUIRE, agent_pool[1]);
    send_cmd(MODE_FAIL, agent_pool[1]);
    send_cmd(MODE_ACQUIRE, agent_pool[1]);
    send_cmd(MODE_FAIL_ACQUIRE, agent_pool[1]);
    send_cmd(MODE_FAIL_ACQUIRE, agent_pool[1]);
    repeat (3) send_cmd(MODE_TICK, agent_pool[1]);
    send_cmd(MODE_ACQUIRE, agent_pool[2]);
  endtask

  task automatic test_absent_slots();
    settle();
    write_reg(REG_PRESENT_MASK, 16'hFFFE);
    send_cmd(MODE_LOOKUP, agent_pool[2]);
    send_cmd(MODE_RELEASE, agent_pool[2]);
    send_cmd(MODE_FAIL, agent_pool[2]);
    send_cmd(MODE_ACQUIRE, agent_pool[2]);
    send_cmd(MODE_TICK, agent_pool[2]);
    settle();
    write_reg(REG_PRESENT_MASK, 16'hFFFF);
    send_cmd(MODE_LOOKUP, agent_pool[2]);
    send_cmd(MODE_RELEASE, agent_pool[2]);
  endtask

  task automatic test_random(input logic [MaskW-1:0] mask, input logic [StepW-1:0] step,
                             input int unsigned count);
    logic [ModeW-1:0]  mode;
    logic [AgentW-1:0] agent;
    int unsigned       pick;
    settle();
    write_reg(REG_PRESENT_MASK, mask);
    write_reg(REG_BACKOFF_STEP, {StepW'($urandom), step});
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 28)      mode = MODE_ACQUIRE;
      else if (pick < 40) mode = MODE_RELEASE;
      else if (pick < 52) mode = MODE_FAIL;
      else if (pick < 62) mode = MODE_FAIL_ACQUIRE;
      else if (pick < 80) mode = MODE_TICK;
      else if (pick < 96) mode = MODE_LOOKUP;
      else                mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      pick = $urandom_range(0, 19);
      if (pick == 0)      agent = NO_OWNER;
      else if (pick == 1) agent = $urandom;
      else                agent = agent_pool[$urandom_range(0, PoolSize - 1)];
      send_cmd(mode, agent);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    mode_i      = '0;
    agent_id_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    errors      = 0;
    idle_en     = 1'b1;
    present_q   = '0;
    step_q      = BACKOFF_RESET;
    for (int i = 0; i < NumSlots; i++) begin
      owner_q[i]      = NO_OWNER;
      fail_count_q[i] = '0;
      penalty_q[i]    = '0;
    end
    for (int k = 0; k < PoolSize; k++) begin
      do agent_pool[k] = $urandom; while (agent_pool[k] == NO_OWNER);
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_config_regs();
    test_grant_order();
    test_fail_backoff();
    test_absent_slots();
    test_random(16'hFFFF, 8'd0, 250);
    test_random(MaskW'($urandom), 8'd1, 250);
    test_random(16'h0000, StepW'($urandom), 100);
    test_random(MaskW'($urandom), StepW'($urandom_range(0, 7)), 250);
    test_random(MaskW'($urandom), 8'hFF, 250);
    idle_en = 1'b0;
    test_random(16'hFFFF, 8'd2, 250);
    settle();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/psab_pkg.sv
sv/psab_slot.sv
sv/priority_server_allocator_backoff.sv
verif/priority_server_allocator_backoff_tb.sv
